FILE: hdl/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types, constants and the exponent table of the convex upsampling
// softmax unit.
// ----------------------------------------------------------------------------
package sca_pkg;

    localparam int NEIGHBOURS      = 9;
    localparam int SLOT_W          = $clog2(NEIGHBOURS);
    localparam int SCORE_W         = 16;
    localparam int SCALE_W         = 5;
    localparam int OUT_W           = 24;
    localparam int FLOW_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int E_W             = 17;
    localparam int SUM_W           = 20;
    localparam int U_W             = 23;
    localparam int IP_W            = 7;
    localparam int STEP_W          = 5;
    localparam int DIV_STEPS       = 17;
    localparam int IP_LIMIT        = 20;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd8;
    localparam logic [16:0]        LOG2E_Q16   = 17'd94548;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_EXP,
        ST_DIV,
        ST_MAC,
        ST_FIN
    } state_t;

    function automatic logic [E_W-1:0] pow2_neg(input logic [4:0] idx);
        logic [E_W-1:0] val;
        case (idx)
            5'd0:    val = 17'd65536;
            5'd1:    val = 17'd62757;
            5'd2:    val = 17'd60097;
            5'd3:    val = 17'd57549;
            5'd4:    val = 17'd55109;
            5'd5:    val = 17'd52773;
            5'd6:    val = 17'd50535;
            5'd7:    val = 17'd48393;
            5'd8:    val = 17'd46341;
            5'd9:    val = 17'd44376;
            5'd10:   val = 17'd42495;
            5'd11:   val = 17'd40693;
            5'd12:   val = 17'd38968;
            5'd13:   val = 17'd37316;
            5'd14:   val = 17'd35734;
            5'd15:   val = 17'd34219;
            5'd16:   val = 17'd32768;
            default: val = 17'd32768;
        endcase
        return val;
    endfunction

endpackage

FILE: hdl/softmax_convex_upsample_unit.sv
// ----------------------------------------------------------------------------
// softmax_convex_upsample_unit
// Softmax-weighted 3x3 convex upsampling of flow, one result per nine
// neighbour requests.
//
// Channel  | Handshake                    | Payload
// input    | start in, busy out           | score, flow_x, flow_y, in_bounds
// result   | result_strobe out            | up_x, up_y
// config   | cfg_valid in, cfg_ready out  | cfg_data (scale factor)
//
// A request is taken into a queue of QUEUE_DEPTH entries, four by default.
// Each group of nine is worked out in the back end after its ninth request
// leaves the queue: first the exponents of all nine, then a division and a
// multiply-accumulate for each neighbour in turn, all on one shared datapath,
// then the scaling. The results leave on a one-cycle strobe in the cycle after
// the scaling; busy is high exactly when the queue is full.
// Reset clears the control state and sets the scale factor to 8.
// ----------------------------------------------------------------------------
module softmax_convex_upsample_unit #(
    parameter int FLOW_BITS   = sca_pkg::FLOW_BITS_DEF,
    parameter int QUEUE_DEPTH = sca_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [15:0]                score,
    input  logic signed [FLOW_BITS-1:0]       flow_x,
    input  logic signed [FLOW_BITS-1:0]       flow_y,
    input  logic                              in_bounds,
    output logic                              result_strobe,
    output logic signed [sca_pkg::OUT_W-1:0]  up_x,
    output logic signed [sca_pkg::OUT_W-1:0]  up_y,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sca_pkg::SCALE_W-1:0]       cfg_data
);

    localparam int ENTRY_W = sca_pkg::SLOT_W + sca_pkg::SCORE_W + 2 * FLOW_BITS;

    logic [sca_pkg::SCALE_W-1:0] scale_reg;
    logic                        push;
    logic                        pop;
    logic                        queue_full;
    logic                        queue_empty;
    logic [ENTRY_W-1:0]          push_data;
    logic [ENTRY_W-1:0]          pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= sca_pkg::SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scale_reg <= cfg_data;
        end
    end

    sca_front #(
        .FLOW_BITS (FLOW_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .queue_full (queue_full),
        .score      (score),
        .flow_x     (flow_x),
        .flow_y     (flow_y),
        .in_bounds  (in_bounds),
        .busy       (busy),
        .push       (push),
        .push_data  (push_data)
    );

    sca_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    sca_back #(
        .FLOW_BITS (FLOW_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (queue_empty),
        .pop_data      (pop_data),
        .scale         (scale_reg),
        .pop           (pop),
        .up_x          (up_x),
        .up_y          (up_y),
        .result_strobe (result_strobe)
    );

endmodule

FILE: hdl/sca_queue.sv
// ----------------------------------------------------------------------------
// sca_queue
// Small first-in first-out queue of classified neighbour requests.
// ----------------------------------------------------------------------------
module sca_queue #(
    parameter int WIDTH = 40,
    parameter int DEPTH = sca_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/sca_front.sv
// ----------------------------------------------------------------------------
// sca_front
// Accepts neighbour requests, numbers them within their group and zeroes the
// flow of out-of-bounds neighbours.
// ----------------------------------------------------------------------------
module sca_front #(
    parameter int FLOW_BITS = sca_pkg::FLOW_BITS_DEF,
    parameter int ENTRY_W   = sca_pkg::SLOT_W + sca_pkg::SCORE_W + 2 * FLOW_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        queue_full,
    input  logic signed [15:0]          score,
    input  logic signed [FLOW_BITS-1:0] flow_x,
    input  logic signed [FLOW_BITS-1:0] flow_y,
    input  logic                        in_bounds,
    output logic                        busy,
    output logic                        push,
    output logic [ENTRY_W-1:0]          push_data
);

    logic [sca_pkg::SLOT_W-1:0] slot_reg;
    logic [sca_pkg::SLOT_W-1:0] slot_next;
    logic [FLOW_BITS-1:0]       fx;
    logic [FLOW_BITS-1:0]       fy;

    assign busy = queue_full;
    assign push = start && !queue_full;
    assign fx   = in_bounds ? flow_x : '0;
    assign fy   = in_bounds ? flow_y : '0;

    assign push_data = {slot_reg, score, fx, fy};

    always_comb
    begin
        slot_next = slot_reg;
        if (push)
        begin
            slot_next = (slot_reg == sca_pkg::SLOT_W'(sca_pkg::NEIGHBOURS - 1)) ?
                        '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

FILE: hdl/sca_back.sv
// ----------------------------------------------------------------------------
// sca_back
// Gathers one group of nine neighbours and runs the softmax, the weighted flow
// sums and the output scaling on a shared sequential datapath.
// ----------------------------------------------------------------------------
module sca_back #(
    parameter int FLOW_BITS = sca_pkg::FLOW_BITS_DEF,
    parameter int ENTRY_W   = sca_pkg::SLOT_W + sca_pkg::SCORE_W + 2 * FLOW_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                queue_empty,
    input  logic [ENTRY_W-1:0]                  pop_data,
    input  logic [sca_pkg::SCALE_W-1:0]         scale,
    output logic                                pop,
    output logic signed [sca_pkg::OUT_W-1:0]    up_x,
    output logic signed [sca_pkg::OUT_W-1:0]    up_y,
    output logic                                result_strobe
);

    localparam int SLOT_W = sca_pkg::SLOT_W;
    localparam int E_W    = sca_pkg::E_W;
    localparam int P_W    = FLOW_BITS + 18;
    localparam int ACC_W  = FLOW_BITS + 22;
    localparam int T_W    = ACC_W + 6;
    localparam int NUM_W  = 34;
    localparam int REM_W  = 21;
    localparam int LOW_W  = 17;

    sca_pkg::state_t state_reg;
    sca_pkg::state_t state_next;

    logic [SLOT_W-1:0]              idx_reg;
    logic [sca_pkg::STEP_W-1:0]     step_reg;
    logic                           strobe_reg;

    logic signed [15:0]             score_mem [sca_pkg::NEIGHBOURS];
    logic signed [FLOW_BITS-1:0]    fx_mem [sca_pkg::NEIGHBOURS];
    logic signed [FLOW_BITS-1:0]    fy_mem [sca_pkg::NEIGHBOURS];
    logic [E_W-1:0]                 e_mem [sca_pkg::NEIGHBOURS];

    logic signed [15:0]             max_reg;
    logic [sca_pkg::U_W-1:0]        u_reg;
    logic [24:0]                    prod_reg;
    logic [E_W-1:0]                 hi_reg;
    logic [sca_pkg::IP_W-1:0]       ip_reg;
    logic [sca_pkg::SUM_W-1:0]      s_reg;
    logic [REM_W-1:0]               rem_reg;
    logic [LOW_W-1:0]               low_reg;
    logic [E_W-1:0]                 quo_reg;
    logic signed [P_W-1:0]          px_reg;
    logic signed [P_W-1:0]          py_reg;
    logic signed [ACC_W-1:0]        acc_x_reg;
    logic signed [ACC_W-1:0]        acc_y_reg;
    logic signed [T_W-1:0]          tx_reg;
    logic signed [T_W-1:0]          ty_reg;
    logic [sca_pkg::OUT_W-1:0]      up_x_reg;
    logic [sca_pkg::OUT_W-1:0]      up_y_reg;

    logic [SLOT_W-1:0]              in_slot;
    logic signed [15:0]             in_score;
    logic signed [FLOW_BITS-1:0]    in_fx;
    logic signed [FLOW_BITS-1:0]    in_fy;
    logic                           last_idx;

    logic [16:0]                    diff_w;
    logic [32:0]                    dmul;
    logic [3:0]                     tab_idx;
    logic [E_W-1:0]                 tab_hi;
    logic [E_W-1:0]                 tab_lo;
    logic [E_W-1:0]                 v_val;
    logic [E_W:0]                   v_round;
    logic [E_W-1:0]                 e_val;
    logic [NUM_W-1:0]               num;
    logic [REM_W:0]                 trial;
    logic                           trial_ok;

    function automatic logic [sca_pkg::OUT_W-1:0] saturate(input logic signed [T_W-1:0] t);
        logic signed [T_W-1:0] q;
        logic [sca_pkg::OUT_W-1:0] r;
        q = t >>> 16;
        if (q > T_W'(8388607))
        begin
            r = 24'h7FFFFF;
        end
        else if (q < T_W'(-8388608))
        begin
            r = 24'h800000;
        end
        else
        begin
            r = q[sca_pkg::OUT_W-1:0];
        end
        return r;
    endfunction

    assign {in_slot, in_score, in_fx, in_fy} = pop_data;
    assign last_idx = (idx_reg == SLOT_W'(sca_pkg::NEIGHBOURS - 1));

    always_comb
    begin
        diff_w  = 17'(max_reg) - 17'(score_mem[idx_reg]);
        dmul    = 33'(diff_w[15:0]) * 33'(sca_pkg::LOG2E_Q16);
        tab_idx = u_reg[15:12];
        tab_hi  = sca_pkg::pow2_neg({1'b0, tab_idx});
        tab_lo  = sca_pkg::pow2_neg(5'({1'b0, tab_idx}) + 5'd1);
        v_val   = hi_reg - E_W'((prod_reg + 25'd2048) >> 12);
        if (ip_reg == '0)
        begin
            v_round = '0;
            e_val   = v_val;
        end
        else if (ip_reg > sca_pkg::IP_W'(sca_pkg::IP_LIMIT))
        begin
            v_round = '0;
            e_val   = '0;
        end
        else
        begin
            v_round = (18'(v_val) + (18'd1 << (ip_reg - 1'b1))) >> ip_reg;
            e_val   = v_round[E_W-1:0];
        end
        num      = NUM_W'({e_mem[idx_reg], 16'b0}) + NUM_W'(s_reg >> 1);
        trial    = {rem_reg, low_reg[LOW_W-1]} - (REM_W + 1)'(s_reg);
        trial_ok = ({rem_reg, low_reg[LOW_W-1]} >= (REM_W + 1)'(s_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sca_pkg::ST_COLLECT:
            begin
                if (!queue_empty && in_slot == SLOT_W'(sca_pkg::NEIGHBOURS - 1))
                begin
                    state_next = sca_pkg::ST_EXP;
                end
            end
            sca_pkg::ST_EXP:
            begin
                if (step_reg == 5'd2 && last_idx)
                begin
                    state_next = sca_pkg::ST_DIV;
                end
            end
            sca_pkg::ST_DIV:
            begin
                if (step_reg == 5'(sca_pkg::DIV_STEPS))
                begin
                    state_next = sca_pkg::ST_MAC;
                end
            end
            sca_pkg::ST_MAC:
            begin
                if (step_reg == 5'd1)
                begin
                    state_next = last_idx ? sca_pkg::ST_FIN : sca_pkg::ST_DIV;
                end
            end
            sca_pkg::ST_FIN:
            begin
                if (step_reg == 5'd1)
                begin
                    state_next = sca_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = sca_pkg::ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        pop           = (state_reg == sca_pkg::ST_COLLECT) && !queue_empty;
        result_strobe = strobe_reg;
        up_x          = up_x_reg;
        up_y          = up_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sca_pkg::ST_COLLECT;
            idx_reg    <= '0;
            step_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == sca_pkg::ST_FIN) && (step_reg == 5'd1);
            if (state_next != state_reg)
            begin
                step_reg <= '0;
                if (state_reg == sca_pkg::ST_COLLECT || state_reg == sca_pkg::ST_EXP)
                begin
                    idx_reg <= '0;
                end
                else if (state_reg == sca_pkg::ST_MAC)
                begin
                    idx_reg <= last_idx ? '0 : idx_reg + 1'b1;
                end
            end
            else if (state_reg == sca_pkg::ST_EXP && step_reg == 5'd2)
            begin
                step_reg <= '0;
                idx_reg  <= idx_reg + 1'b1;
            end
            else if (state_reg != sca_pkg::ST_COLLECT)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sca_pkg::ST_COLLECT:
            begin
                if (pop)
                begin
                    score_mem[in_slot] <= in_score;
                    fx_mem[in_slot]    <= in_fx;
                    fy_mem[in_slot]    <= in_fy;
                    if (in_slot == '0 || in_score > max_reg)
                    begin
                        max_reg <= in_score;
                    end
                end
                s_reg     <= '0;
                acc_x_reg <= '0;
                acc_y_reg <= '0;
            end
            sca_pkg::ST_EXP:
            begin
                case (step_reg)
                    5'd0:
                    begin
                        u_reg <= sca_pkg::U_W'((dmul + 33'd512) >> 10);
                    end
                    5'd1:
                    begin
                        prod_reg <= 25'(12'(tab_hi - tab_lo)) * 25'(u_reg[11:0]);
                        hi_reg   <= tab_hi;
                        ip_reg   <= u_reg[sca_pkg::U_W-1:16];
                    end
                    default:
                    begin
                        e_mem[idx_reg] <= e_val;
                        s_reg          <= s_reg + sca_pkg::SUM_W'(e_val);
                    end
                endcase
            end
            sca_pkg::ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    rem_reg <= REM_W'(num[NUM_W-1:LOW_W]);
                    low_reg <= num[LOW_W-1:0];
                    quo_reg <= '0;
                end
                else
                begin
                    rem_reg <= trial_ok ? trial[REM_W-1:0] :
                               {rem_reg[REM_W-2:0], low_reg[LOW_W-1]};
                    low_reg <= {low_reg[LOW_W-2:0], 1'b0};
                    quo_reg <= {quo_reg[E_W-2:0], trial_ok};
                end
            end
            sca_pkg::ST_MAC:
            begin
                if (step_reg == '0)
                begin
                    px_reg <= P_W'($signed({1'b0, quo_reg})) * P_W'(fx_mem[idx_reg]);
                    py_reg <= P_W'($signed({1'b0, quo_reg})) * P_W'(fy_mem[idx_reg]);
                end
                else
                begin
                    acc_x_reg <= acc_x_reg + ACC_W'(px_reg);
                    acc_y_reg <= acc_y_reg + ACC_W'(py_reg);
                end
            end
            sca_pkg::ST_FIN:
            begin
                if (step_reg == '0)
                begin
                    tx_reg <= T_W'(acc_x_reg) * T_W'($signed({1'b0, scale})) + T_W'(32768);
                    ty_reg <= T_W'(acc_y_reg) * T_W'($signed({1'b0, scale})) + T_W'(32768);
                end
                else
                begin
                    up_x_reg <= saturate(tx_reg);
                    up_y_reg <= saturate(ty_reg);
                end
            end
            default:
            begin
                s_reg <= s_reg;
            end
        endcase
    end

endmodule

FILE: hdl/sca_checker.sv
// ----------------------------------------------------------------------------
// sca_checker
// Port-level checks of the convex upsampling unit, bound to the top level.
// ----------------------------------------------------------------------------
module sca_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_strobe,
    input logic cfg_ready
);

    logic [3:0] seen_reg;
    logic [3:0] pending_reg;
    logic       group_done;

    assign group_done = start && !busy && (seen_reg == 4'd8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                seen_reg <= (seen_reg == 4'd8) ? 4'd0 : seen_reg + 4'd1;
            end
            if (group_done && !result_strobe)
            begin
                pending_reg <= pending_reg + 4'd1;
            end
            else if (result_strobe && !group_done && pending_reg != 4'd0)
            begin
                pending_reg <= pending_reg - 4'd1;
            end
        end
    end

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("result strobe held for more than one cycle");

    a_strobe_has_group: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (pending_reg != 4'd0))
        else $error("result without a completed group of nine requests");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind softmax_convex_upsample_unit sca_checker u_sca_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .cfg_ready     (cfg_ready)
);
